/* hw/rtl/rpn_pkg.sv */
// rpn_pkg: shared constants for the reverse-Polish stack evaluator
// operator codes, status codes, default sizes and iteration counts
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_FRAC_BITS   = 16;

  // operator codes carried with an operator request
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  // status codes returned with each result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  // iterations of the shared adder for multiply and divide
  localparam logic [5:0] MUL_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS = 6'd33;

  // saturation limits
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

/* hw/rtl/rpn_stack_evaluator.sv */
// rpn_stack_evaluator: reverse-Polish evaluator on a fixed-point operand stack
// one shared 34-bit adder serves add, subtract, shift-add multiply and divide
// depends on rpn_pkg
// a divide skips its steps when it saturates early or divides by zero; a last token adds
//   a read of the top before the result is emitted
// throughput: one token at a time; multiply and divide are set by the one-bit-per-cycle
//   passes through the shared adder, the rest by the registered stack memory reads
// reset: rst (synchronous) empties the stack, clears the sticky error and drops the
//   output valid; stack memory and output data are not cleared and need no sweep
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
  parameter int FRAC_BITS   = rpn_pkg::DEF_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // token request
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] operand_value
  input  wire logic [3:0]  s_tuser,   // [0] cmd, [3:1] op_code
  input  wire logic        s_tlast,   // last_token
  // result request
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] result_value
  output logic [1:0]       m_tuser    // [1:0] status
);

  import rpn_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);
  localparam logic [31:0] ONE_FX  = 32'd1 << FRAC_BITS;
  localparam logic [31:0] NEG_ONE = ~ONE_FX + 32'd1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FETCH = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_SAT   = 9'b000100000,
    S_PUSH  = 9'b001000000,
    S_TOP   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t          state, state_next;
  logic [SPW-1:0]  sp, sp_next;
  logic [1:0]      err, err_next;
  logic [5:0]      count, count_next;

  logic            tok_cmd;
  logic [31:0]     tok_val;
  logic [2:0]      tok_op;
  logic            tok_last;

  logic [31:0]     acc_hi, acc_hi_next;
  logic [32:0]     acc_lo, acc_lo_next;
  logic [31:0]     opnd, opnd_next;
  logic            neg, neg_next;
  logic [31:0]     res, res_next;

  logic            out_load;
  logic [31:0]     out_data;
  logic [1:0]      out_status;

  // stack memory and its ports
  logic [31:0]     stack_mem [STACK_DEPTH];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic [AW-1:0]   rd_addr_a, rd_addr_b;
  logic [31:0]     rd_a, rd_b;
  logic [SPW-1:0]  sp_m1, sp_m2;

  // shared adder
  logic [33:0]     alu_a, alu_b, alu_y;
  logic            alu_sub;

  // operand magnitudes and divide setup
  logic [31:0]     lmag, rmag;
  logic [63:0]     dvd_full;
  logic [63:0]     mag;
  logic [32:0]     trial;

  assign sp_m1     = sp - SPW'(1);
  assign sp_m2     = sp - SPW'(2);
  assign rd_addr_a = sp_m1[AW-1:0];
  assign rd_addr_b = sp_m2[AW-1:0];

  assign s_tready = (state == S_IDLE);

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= stack_mem[rd_addr_a];
    rd_b <= stack_mem[rd_addr_b];
  end

  // operand magnitudes; left is the deeper entry, right the top
  assign lmag     = rd_b[31] ? (~rd_b + 32'd1) : rd_b;
  assign rmag     = rd_a[31] ? (~rd_a + 32'd1) : rd_a;
  assign dvd_full = {32'd0, lmag} << FRAC_BITS;
  assign trial    = {acc_hi, acc_lo[32]};

  // shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_LOAD: begin
        alu_a   = {{2{rd_b[31]}}, rd_b};
        alu_b   = {{2{rd_a[31]}}, rd_a};
        alu_sub = (tok_op == OP_SUB);
      end
      S_MUL: begin
        alu_a = {2'b00, acc_hi};
        alu_b = acc_lo[0] ? {2'b00, opnd} : 34'd0;
      end
      S_DIV: begin
        alu_a   = {1'b0, trial};
        alu_b   = {2'b00, opnd};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_y = alu_a + (alu_b ^ {34{alu_sub}}) + {33'd0, alu_sub};

  // magnitude of the finished product or quotient
  assign mag = (tok_op == OP_MUL) ? ({acc_hi, acc_lo[31:0]} >> FRAC_BITS)
                                  : {31'd0, acc_lo};

  // sequencer
  always_comb begin
    state_next  = state;
    sp_next     = sp;
    err_next    = err;
    count_next  = count;
    acc_hi_next = acc_hi;
    acc_lo_next = acc_lo;
    opnd_next   = opnd;
    neg_next    = neg;
    res_next    = res;
    mem_we      = 1'b0;
    mem_waddr   = sp[AW-1:0];
    mem_wdata   = tok_val;
    out_load    = 1'b0;
    out_data    = rd_a;
    out_status  = err;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_FETCH;
        end
      end
      // push directly, or check depth before an operator
      S_FETCH: begin
        if (!tok_cmd) begin
          if (sp == SP_FULL) begin
            if (err == ST_OK) err_next = ST_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            sp_next = sp + SPW'(1);
          end
          state_next = tok_last ? S_TOP : S_IDLE;
        end else if (sp < SP_TWO) begin
          if (err == ST_OK) err_next = ST_UNDERFLOW;
          state_next = tok_last ? S_TOP : S_IDLE;
        end else begin
          state_next = S_LOAD;
        end
      end
      // operands are in the read registers
      S_LOAD: begin
        neg_next   = rd_a[31] ^ rd_b[31];
        count_next = '0;
        state_next = S_PUSH;
        case (tok_op)
          OP_ADD, OP_SUB: begin
            if (!alu_y[33] && (alu_y[32:31] != 2'b00)) begin
              res_next = VAL_MAX;
            end else if (alu_y[33] && (alu_y[32:31] != 2'b11)) begin
              res_next = VAL_MIN;
            end else begin
              res_next = alu_y[31:0];
            end
          end
          OP_MUL: begin
            acc_hi_next = '0;
            acc_lo_next = {1'b0, rmag};
            opnd_next   = lmag;
            state_next  = S_MUL;
          end
          OP_DIV: begin
            if (rd_a == 32'd0) begin
              if (err == ST_OK) err_next = ST_DIVZERO;
              if (rd_b == 32'd0) begin
                res_next = 32'd0;
              end else begin
                res_next = rd_b[31] ? VAL_MIN : VAL_MAX;
              end
            end else if ({1'b0, dvd_full[63:33]} >= rmag) begin
              // quotient needs more than 33 bits
              res_next = (rd_a[31] ^ rd_b[31]) ? VAL_MIN : VAL_MAX;
            end else begin
              acc_hi_next = {1'b0, dvd_full[63:33]};
              acc_lo_next = dvd_full[32:0];
              opnd_next   = rmag;
              state_next  = S_DIV;
            end
          end
          default: begin
            res_next = NEG_ONE;
          end
        endcase
      end
      // shift-add multiply, one multiplier bit a cycle
      S_MUL: begin
        acc_hi_next = alu_y[32:1];
        acc_lo_next = {1'b0, alu_y[0], acc_lo[31:1]};
        count_next  = count + 6'd1;
        if (count == MUL_STEPS - 6'd1) state_next = S_SAT;
      end
      // restoring divide, one quotient bit a cycle
      S_DIV: begin
        acc_hi_next = alu_y[33] ? trial[31:0] : alu_y[31:0];
        acc_lo_next = {acc_lo[31:0], ~alu_y[33]};
        count_next  = count + 6'd1;
        if (count == DIV_STEPS - 6'd1) state_next = S_SAT;
      end
      // apply sign and saturate
      S_SAT: begin
        if (neg) begin
          res_next = (mag > 64'h0000_0000_8000_0000) ? VAL_MIN : (~mag[31:0] + 32'd1);
        end else begin
          res_next = (mag > 64'h0000_0000_7FFF_FFFF) ? VAL_MAX : mag[31:0];
        end
        state_next = S_PUSH;
      end
      // replace the two operands with the result
      S_PUSH: begin
        mem_we     = 1'b1;
        mem_waddr  = sp_m2[AW-1:0];
        mem_wdata  = res;
        sp_next    = sp_m1;
        state_next = tok_last ? S_TOP : S_IDLE;
      end
      // read address of the top is presented
      S_TOP: begin
        state_next = S_EMIT;
      end
      // load the output register once it is free
      S_EMIT: begin
        if (sp == '0) begin
          out_data = 32'd0;
          if (err == ST_OK) out_status = ST_UNDERFLOW;
        end
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          sp_next    = '0;
          err_next   = ST_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sp       <= '0;
      err      <= ST_OK;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      err   <= err_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      tok_cmd  <= s_tuser[0];
      tok_op   <= s_tuser[3:1];
      tok_val  <= s_tdata;
      tok_last <= s_tlast;
    end
    acc_hi <= acc_hi_next;
    acc_lo <= acc_lo_next;
    opnd   <= opnd_next;
    neg    <= neg_next;
    res    <= res_next;
    if (out_load) begin
      m_tdata <= out_data;
      m_tuser <= out_status;
    end
  end

  // checks
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_FULL)
    else $error("stack pointer beyond depth");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_EMIT))
    else $error("result loaded outside emit");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!m_tvalid || m_tready)) |=> (sp == '0 && err == ST_OK))
    else $error("stack not cleared after result");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (count < MUL_STEPS))
    else $error("multiply ran past its steps");

endmodule

`default_nettype wire

/* bench/rpn_stack_evaluator_tb.sv */
// rpn_stack_evaluator_tb: self-checking bench for the reverse-Polish stack evaluator
// streams token requests, predicts each expression result and checks the results in order
// depends on rpn_pkg and rpn_stack_evaluator
`timescale 1ns / 1ps

module rpn_stack_evaluator_tb;
  import rpn_pkg::*;

  localparam int          DEPTH        = DEF_STACK_DEPTH;
  localparam int          FRAC         = DEF_FRAC_BITS;
  localparam longint      Q_ONE        = longint'(1) << FRAC;
  localparam int          ITEM_GOAL    = 1350;
  localparam int          QUIET_TAIL   = 150;     // last tokens go without idling
  localparam int          HOLD_START   = 3000;    // long receiver hold-off
  localparam int          HOLD_LEN     = 500;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          CYCLE_LIMIT  = 500_000;

  localparam logic        CMD_PUSH     = 1'b0;
  localparam logic        CMD_OPER     = 1'b1;
  // codes above divide push -1.0
  localparam logic [2:0]  OP_OTHER_LO  = 3'd4;
  localparam logic [2:0]  OP_OTHER_HI  = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [31:0] value;
    logic [2:0]  op;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } outcome_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [3:0]  s_tuser  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  token_t             pending_tokens[$];
  outcome_t           expected_outcomes[$];
  logic signed [31:0] calc_stack [DEPTH];
  int                 calc_depth = 0;
  logic [1:0]         calc_error = ST_OK;
  logic               quiet_tail = 1'b0;
  int                 error_count = 0;

  rpn_stack_evaluator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // saturate a wide intermediate to 32 bits
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'($signed(VAL_MAX))) return VAL_MAX;
    if (v < longint'($signed(VAL_MIN))) return VAL_MIN;
    return v[31:0];
  endfunction

  // keep only the first error of an expression
  task automatic note_fault(input logic [1:0] code);
    if (calc_error == ST_OK) calc_error = code;
  endtask

  // advance the predicted stack by one token, queue the outcome on a last token
  task automatic evaluate_token(input token_t t);
    logic signed [31:0] lhs, rhs, res;
    outcome_t           o;
    if (t.cmd == CMD_PUSH) begin
      if (calc_depth >= DEPTH) note_fault(ST_OVERFLOW);
      else begin
        calc_stack[calc_depth] = t.value;
        calc_depth++;
      end
    end else if (calc_depth < 2) begin
      note_fault(ST_UNDERFLOW);
    end else begin
      rhs = calc_stack[calc_depth - 1];
      lhs = calc_stack[calc_depth - 2];
      case (t.op)
        OP_ADD: res = clamp32(longint'(lhs) + longint'(rhs));
        OP_SUB: res = clamp32(longint'(lhs) - longint'(rhs));
        OP_MUL: res = clamp32((longint'(lhs) * longint'(rhs)) / Q_ONE);
        OP_DIV: begin
          if (rhs == 0) begin
            note_fault(ST_DIVZERO);
            res = (lhs > 0) ? VAL_MAX : (lhs < 0) ? VAL_MIN : '0;
          end else begin
            res = clamp32((longint'(lhs) * Q_ONE) / longint'(rhs));
          end
        end
        default: res = 32'(-Q_ONE);
      endcase
      calc_depth--;
      calc_stack[calc_depth - 1] = res;
    end
    if (t.last) begin
      o.status = calc_error;
      o.value  = '0;
      if (calc_depth >= 1) o.value = calc_stack[calc_depth - 1];
      else if (o.status == ST_OK) o.status = ST_UNDERFLOW;
      expected_outcomes = {expected_outcomes, o};
      calc_depth = 0;
      calc_error = ST_OK;
    end
  endtask

  // operand mix: extremes, zero, small fixed-point values, raw random words
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return ($urandom_range(0, 1) != 0) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5, 6: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    if ($urandom_range(0, 7) == 0) return 3'($urandom_range(OP_OTHER_LO, OP_OTHER_HI));
    return 3'($urandom_range(OP_ADD, OP_DIV));
  endfunction

  task automatic add_token(input logic cmd, input logic [31:0] value,
                           input logic [2:0] op, input logic last);
    token_t t;
    t.cmd   = cmd;
    t.value = value;
    t.op    = op;
    t.last  = last;
    pending_tokens = {pending_tokens, t};
  endtask

  // well-formed expression with random content, occasionally deep enough to overflow
  task automatic add_expression();
    int n_vals, pushed, held;
    n_vals = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
    pushed = 0;
    held   = 0;
    while (pushed < n_vals || held > 1) begin
      if (pushed < n_vals && (held < 2 || $urandom_range(0, 2) != 0)) begin
        pushed++;
        held++;
        add_token(CMD_PUSH, pick_operand(), 3'($urandom_range(0, 7)),
                  pushed == n_vals && held == 1);
      end else begin
        held--;
        add_token(CMD_OPER, $urandom(), pick_op(), pushed == n_vals && held == 1);
      end
    end
  endtask

  // stimulus, reset and end of run
  initial begin : run_control
    // overflow first, then every operator on the stack it filled, error stays overflow
    for (int i = 0; i <= DEPTH; i++) begin
      case (i % 4)
        0: add_token(CMD_PUSH, VAL_MAX, OP_ADD, 1'b0);
        1: add_token(CMD_PUSH, VAL_MIN, OP_ADD, 1'b0);
        2: add_token(CMD_PUSH, 32'h0003_8000, OP_ADD, 1'b0);
        default: add_token(CMD_PUSH, 32'h0000_0000, OP_ADD, 1'b0);
      endcase
    end
    add_token(CMD_OPER, 32'hFFFF_FFFF, OP_ADD, 1'b0);
    add_token(CMD_OPER, 32'h0000_0000, OP_SUB, 1'b0);
    add_token(CMD_OPER, 32'hFFFF_FFFF, OP_MUL, 1'b0);
    add_token(CMD_OPER, 32'h0000_0000, OP_DIV, 1'b0);
    add_token(CMD_OPER, 32'hFFFF_FFFF, OP_OTHER_HI, 1'b1);
    // operator and last token on an empty stack
    add_token(CMD_OPER, 32'h0000_0000, OP_ADD, 1'b1);
    // divide by zero with a positive left operand
    add_token(CMD_PUSH, 32'h0005_0000, OP_ADD, 1'b0);
    add_token(CMD_PUSH, 32'h0000_0000, OP_ADD, 1'b0);
    add_token(CMD_OPER, 32'h0000_0000, OP_DIV, 1'b1);

    // random part: mostly expressions, some loose tokens
    while (pending_tokens.size() < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3))
          add_token(1'($urandom_range(0, 1)), $urandom(), 3'($urandom_range(0, 7)),
                    $urandom_range(0, 3) == 0);
      end else begin
        add_expression();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_tokens.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // token request driver with random idle bursts
  always @(posedge clk) begin : token_driver
    int gap_left;
    if (rst) begin
      s_tvalid   <= 1'b0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) evaluate_token(pending_tokens.pop_front());
      quiet_tail <= (pending_tokens.size() <= QUIET_TAIL);
      if (s_tvalid && !s_tready) begin
        // hold the offered token until taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_tokens.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 15);
        s_tvalid <= 1'b0;
      end else if (pending_tokens.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_tokens[0].value;
        s_tuser  <= {pending_tokens[0].op, pending_tokens[0].cmd};
        s_tlast  <= pending_tokens[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result ready: random stall bursts and one long hold-off
  always @(posedge clk) begin : result_ready
    int ready_cycles;
    int stall_left;
    if (rst) begin
      m_tready     <= 1'b0;
      ready_cycles = 0;
      stall_left   = 0;
    end else begin
      ready_cycles++;
      if (ready_cycles >= HOLD_START && ready_cycles < HOLD_START + HOLD_LEN) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each result with the oldest predicted outcome
  always @(posedge clk) begin : result_monitor
    outcome_t o;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result: result_value %h status %0d", m_tdata, m_tuser);
        error_count++;
      end else begin
        o = expected_outcomes.pop_front();
        if (m_tdata !== o.value) begin
          $error("result_value: expected %h, actual %h", o.value, m_tdata);
          error_count++;
        end
        if (m_tuser !== o.status) begin
          $error("status: expected %0d, actual %0d", o.status, m_tuser);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    int cycle_count;
    if (rst) begin
      cycle_count = 0;
    end else begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_stack_evaluator.sv
bench/rpn_stack_evaluator_tb.sv
